/* hdl/rsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reed-Solomon parity package
// Field arithmetic, generator coefficient tables and control types shared by
// the parity cells and the top level.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam int MAX_PARITY = 68;
    localparam int NUM_SEL    = 16;
    localparam int FLAT_LEN   = 461;
    localparam logic [8:0] GF_POLY = 9'h12D;

    // Parity byte count for each selection index.
    localparam logic [6:0] EC_COUNT [NUM_SEL] = '{
        7'd5, 7'd7, 7'd10, 7'd11, 7'd12, 7'd14, 7'd18, 7'd20,
        7'd24, 7'd28, 7'd36, 7'd42, 7'd48, 7'd56, 7'd62, 7'd68
    };

    // Offset of each polynomial inside the flat coefficient list.
    localparam logic [8:0] GEN_START [NUM_SEL] = '{
        9'd0, 9'd5, 9'd12, 9'd22, 9'd33, 9'd45, 9'd59, 9'd77,
        9'd97, 9'd121, 9'd149, 9'd185, 9'd227, 9'd275, 9'd331, 9'd393
    };

    // All generator polynomials back to back, coefficient 0 first.
    localparam logic [7:0] GEN_FLAT [FLAT_LEN] = '{
        // 5
        8'd228, 8'd48, 8'd15, 8'd111, 8'd62,
        // 7
        8'd23, 8'd68, 8'd144, 8'd134, 8'd240, 8'd92, 8'd254,
        // 10
        8'd28, 8'd24, 8'd185, 8'd166, 8'd223, 8'd248, 8'd116, 8'd255, 8'd110, 8'd61,
        // 11
        8'd175, 8'd138, 8'd205, 8'd12, 8'd194, 8'd168, 8'd39, 8'd245, 8'd60, 8'd97,
        8'd120,
        // 12
        8'd41, 8'd153, 8'd158, 8'd91, 8'd61, 8'd42, 8'd142, 8'd213, 8'd97, 8'd178,
        8'd100, 8'd242,
        // 14
        8'd156, 8'd97, 8'd192, 8'd252, 8'd95, 8'd9, 8'd157, 8'd119, 8'd138, 8'd45,
        8'd18, 8'd186, 8'd83, 8'd185,
        // 18
        8'd83, 8'd195, 8'd100, 8'd39, 8'd188, 8'd75, 8'd66, 8'd61, 8'd241, 8'd213,
        8'd109, 8'd129, 8'd94, 8'd254, 8'd225, 8'd48, 8'd90, 8'd188,
        // 20
        8'd15, 8'd195, 8'd244, 8'd9, 8'd233, 8'd71, 8'd168, 8'd2, 8'd188, 8'd160,
        8'd153, 8'd145, 8'd253, 8'd79, 8'd108, 8'd82, 8'd27, 8'd174, 8'd186, 8'd172,
        // 24
        8'd52, 8'd190, 8'd88, 8'd205, 8'd109, 8'd39, 8'd176, 8'd21, 8'd155, 8'd197,
        8'd251, 8'd223, 8'd155, 8'd21, 8'd5, 8'd172, 8'd254, 8'd124, 8'd12, 8'd181,
        8'd184, 8'd96, 8'd50, 8'd193,
        // 28
        8'd211, 8'd231, 8'd43, 8'd97, 8'd71, 8'd96, 8'd103, 8'd174, 8'd37, 8'd151,
        8'd170, 8'd53, 8'd75, 8'd34, 8'd249, 8'd121, 8'd17, 8'd138, 8'd110, 8'd213,
        8'd141, 8'd136, 8'd120, 8'd151, 8'd233, 8'd168, 8'd93, 8'd255,
        // 36
        8'd245, 8'd127, 8'd242, 8'd218, 8'd130, 8'd250, 8'd162, 8'd181, 8'd102, 8'd120,
        8'd84, 8'd179, 8'd220, 8'd251, 8'd80, 8'd182, 8'd229, 8'd18, 8'd2, 8'd4,
        8'd68, 8'd33, 8'd101, 8'd137, 8'd95, 8'd119, 8'd115, 8'd44, 8'd175, 8'd184,
        8'd59, 8'd25, 8'd225, 8'd98, 8'd81, 8'd112,
        // 42
        8'd77, 8'd193, 8'd137, 8'd31, 8'd19, 8'd38, 8'd22, 8'd153, 8'd247, 8'd105,
        8'd122, 8'd2, 8'd245, 8'd133, 8'd242, 8'd8, 8'd175, 8'd95, 8'd100, 8'd9,
        8'd167, 8'd105, 8'd214, 8'd111, 8'd57, 8'd121, 8'd21, 8'd1, 8'd253, 8'd57,
        8'd54, 8'd101, 8'd248, 8'd202, 8'd69, 8'd50, 8'd150, 8'd177, 8'd226, 8'd5,
        8'd9, 8'd5,
        // 48
        8'd245, 8'd132, 8'd172, 8'd223, 8'd96, 8'd32, 8'd117, 8'd22, 8'd238, 8'd133,
        8'd238, 8'd231, 8'd205, 8'd188, 8'd237, 8'd87, 8'd191, 8'd106, 8'd16, 8'd147,
        8'd118, 8'd23, 8'd37, 8'd90, 8'd170, 8'd205, 8'd131, 8'd88, 8'd120, 8'd100,
        8'd66, 8'd138, 8'd186, 8'd240, 8'd82, 8'd44, 8'd176, 8'd87, 8'd187, 8'd147,
        8'd160, 8'd175, 8'd69, 8'd213, 8'd92, 8'd253, 8'd225, 8'd19,
        // 56
        8'd175, 8'd9, 8'd223, 8'd238, 8'd12, 8'd17, 8'd220, 8'd208, 8'd100, 8'd29,
        8'd175, 8'd170, 8'd230, 8'd192, 8'd215, 8'd235, 8'd150, 8'd159, 8'd36, 8'd223,
        8'd38, 8'd200, 8'd132, 8'd54, 8'd228, 8'd146, 8'd218, 8'd234, 8'd117, 8'd203,
        8'd29, 8'd232, 8'd144, 8'd238, 8'd22, 8'd150, 8'd201, 8'd117, 8'd62, 8'd207,
        8'd164, 8'd13, 8'd137, 8'd245, 8'd127, 8'd67, 8'd247, 8'd28, 8'd155, 8'd43,
        8'd203, 8'd107, 8'd233, 8'd53, 8'd143, 8'd46,
        // 62
        8'd242, 8'd93, 8'd169, 8'd50, 8'd144, 8'd210, 8'd39, 8'd118, 8'd202, 8'd188,
        8'd201, 8'd189, 8'd143, 8'd108, 8'd196, 8'd37, 8'd185, 8'd112, 8'd134, 8'd230,
        8'd245, 8'd63, 8'd197, 8'd190, 8'd250, 8'd106, 8'd185, 8'd221, 8'd175, 8'd64,
        8'd114, 8'd71, 8'd161, 8'd44, 8'd147, 8'd6, 8'd27, 8'd218, 8'd51, 8'd63,
        8'd87, 8'd10, 8'd40, 8'd130, 8'd188, 8'd17, 8'd163, 8'd31, 8'd176, 8'd170,
        8'd4, 8'd107, 8'd232, 8'd7, 8'd94, 8'd166, 8'd224, 8'd124, 8'd86, 8'd47,
        8'd11, 8'd204,
        // 68
        8'd220, 8'd228, 8'd173, 8'd89, 8'd251, 8'd149, 8'd159, 8'd56, 8'd89, 8'd33,
        8'd147, 8'd244, 8'd154, 8'd36, 8'd73, 8'd127, 8'd213, 8'd136, 8'd248, 8'd180,
        8'd234, 8'd197, 8'd158, 8'd177, 8'd68, 8'd122, 8'd93, 8'd213, 8'd15, 8'd160,
        8'd227, 8'd236, 8'd66, 8'd139, 8'd153, 8'd185, 8'd202, 8'd167, 8'd179, 8'd25,
        8'd220, 8'd232, 8'd96, 8'd210, 8'd231, 8'd136, 8'd223, 8'd239, 8'd181, 8'd241,
        8'd59, 8'd52, 8'd172, 8'd25, 8'd49, 8'd232, 8'd211, 8'd189, 8'd64, 8'd54,
        8'd108, 8'd153, 8'd132, 8'd63, 8'd96, 8'd103, 8'd82, 8'd186
    };

    // Control of one LFSR cell.
    typedef struct packed {
        logic clear;
        logic step;
    } lfsr_ctrl_t;

    // Control of one drain cell.
    typedef struct packed {
        logic load;
        logic shift;
    } drain_ctrl_t;

    // GF(256) multiply, shift-and-add over the field polynomial.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] acc_a;
        logic [7:0] prod;
        acc_a = {1'b0, a};
        prod  = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                prod = prod ^ acc_a[7:0];
            end
            acc_a = {acc_a[7:0], 1'b0};
            if (acc_a[8]) begin
                acc_a = acc_a ^ GF_POLY;
            end
        end
        return prod;
    endfunction

    // Coefficient for chain position pos. The active registers sit at the top
    // of the chain, so positions below the offset get a zero coefficient.
    function automatic logic [7:0] gen_coef(input logic [3:0] sel, input int pos);
        int off;
        int idx;
        off = MAX_PARITY - int'(EC_COUNT[sel]);
        idx = int'(GEN_START[sel]) + pos - off;
        if (pos >= off) begin
            return GEN_FLAT[idx[8:0]];
        end
        return 8'd0;
    endfunction

endpackage
`default_nettype wire

/* hdl/rsp_lfsr_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reed-Solomon LFSR cell
// One parity byte of the encoder shift register: takes its neighbor's byte
// plus the feedback times its generator coefficient on every data word.
// ----------------------------------------------------------------------------
module rsp_lfsr_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rsp_pkg::lfsr_ctrl_t ctrl,
    input  wire logic [7:0]         coef,
    input  wire logic [7:0]         feedback,
    input  wire logic [7:0]         prev_byte,
    output logic [7:0]              parity_byte,
    output logic [7:0]              parity_upd
);
    import rsp_pkg::*;

    logic [7:0] parity_reg;
    logic [7:0] parity_next;

    // Value after absorbing the current data word.
    assign parity_upd = prev_byte ^ gf_mul(feedback, coef);

    // Clear wins over a step so a block end starts the next block at zero.
    always_comb begin
        parity_next = parity_reg;
        if (ctrl.clear) begin
            parity_next = 8'd0;
        end else if (ctrl.step) begin
            parity_next = parity_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg <= 8'd0;
        end else begin
            parity_reg <= parity_next;
        end
    end

    assign parity_byte = parity_reg;

endmodule
`default_nettype wire

/* hdl/rsp_drain_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reed-Solomon drain cell
// One byte of the output shift chain: loaded with a finished parity byte and
// moved up two places for every word sent.
// ----------------------------------------------------------------------------
module rsp_drain_cell (
    input  wire logic                aclk,
    input  wire rsp_pkg::drain_ctrl_t ctrl,
    input  wire logic [7:0]          load_byte,
    input  wire logic [7:0]          shift_byte,
    output logic [7:0]               hold_byte
);
    import rsp_pkg::*;

    logic [7:0] hold_reg;
    logic [7:0] hold_next;

    // Load a new parity set, or move two places toward the output end.
    always_comb begin
        hold_next = hold_reg;
        if (ctrl.load) begin
            hold_next = load_byte;
        end else if (ctrl.shift) begin
            hold_next = shift_byte;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

    assign hold_byte = hold_reg;

endmodule
`default_nettype wire

/* hdl/reed_solomon_parity_gf256_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reed-Solomon parity generator, GF(256), polynomial 0x12D
// Systematic encoder: data words in, parity words out after each block.
// ----------------------------------------------------------------------------
// The block takes one data word per cycle into a row of 68 LFSR cells; the
// active parity bytes sit at the top of the row, so the feedback always
// comes from the top cell. The word marked with s_tlast completes a block:
// its parity is copied into a separate drain chain and the LFSR starts over
// at zero, so the next block's data keeps flowing while the parity of the
// last block goes out, two bytes per word, highest register first. Words
// carry one result each and a block of n parity bytes gives ceil(n/2)
// words. A last data word is held off only while the previous parity drains,
// so with m_tready held high, blocks of at least ceil(n/2) words run at one
// word per cycle. Writing cfg_wr_data (the polynomial index 0..15 for
// 5..68 parity bytes) clears the LFSR; write it only while the block is idle.
// ----------------------------------------------------------------------------
module reed_solomon_parity_gf256_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,   // ec_size_select
    // Data words in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] data_byte
    input  wire logic        s_tlast,       // block_end
    // Parity words out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,       // [7:0] parity_first, [15:8] parity_second
    output logic             m_tuser,       // second_valid
    output logic             m_tlast        // final_pair
);
    import rsp_pkg::*;

    logic [3:0]  sel_reg;
    logic [3:0]  sel_next;
    logic [5:0]  remain_reg;
    logic [5:0]  remain_next;
    logic [6:0]  count;
    logic        in_acc;
    logic        out_acc;
    logic        blk_end;
    logic [7:0]  feedback;
    lfsr_ctrl_t  lfsr_ctrl;
    drain_ctrl_t drain_ctrl;
    logic [7:0]  cell_q   [MAX_PARITY];
    logic [7:0]  cell_upd [MAX_PARITY];
    logic [7:0]  drain_q  [MAX_PARITY];

    assign count    = EC_COUNT[sel_reg];
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign blk_end  = in_acc && s_tlast;
    assign feedback = cell_q[MAX_PARITY-1] ^ s_tdata;

    // A last word waits until the drain chain is free or frees this cycle.
    assign s_tready = !s_tlast || (remain_reg == 6'd0)
                      || ((remain_reg == 6'd1) && m_tready);

    // Cell control for both chains.
    always_comb begin
        lfsr_ctrl.clear  = cfg_wr_en || blk_end;
        lfsr_ctrl.step   = in_acc;
        drain_ctrl.load  = blk_end;
        drain_ctrl.shift = out_acc;
    end

    // Selection register and count of words left to send.
    always_comb begin
        sel_next    = sel_reg;
        remain_next = remain_reg;
        if (cfg_wr_en) begin
            sel_next = cfg_wr_data;
        end
        if (blk_end) begin
            remain_next = 6'((count + 7'd1) >> 1);
        end else if (out_acc) begin
            remain_next = remain_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg    <= 4'd0;
            remain_reg <= 6'd0;
        end else begin
            sel_reg    <= sel_next;
            remain_reg <= remain_next;
        end
    end

    // LFSR row and drain row.
    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        logic [7:0] prev_byte;
        logic [7:0] shift_byte;

        if (j == 0) begin : g_first
            assign prev_byte = 8'd0;
        end else begin : g_rest
            assign prev_byte = cell_q[j-1];
        end

        if (j < 2) begin : g_drain_low
            assign shift_byte = 8'd0;
        end else begin : g_drain_up
            assign shift_byte = drain_q[j-2];
        end

        rsp_lfsr_cell u_lfsr (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (lfsr_ctrl),
            .coef        (gen_coef(sel_reg, j)),
            .feedback    (feedback),
            .prev_byte   (prev_byte),
            .parity_byte (cell_q[j]),
            .parity_upd  (cell_upd[j])
        );

        rsp_drain_cell u_drain (
            .aclk       (aclk),
            .ctrl       (drain_ctrl),
            .load_byte  (cell_upd[j]),
            .shift_byte (shift_byte),
            .hold_byte  (drain_q[j])
        );
    end

    // Output word from the top two drain cells. The last word of an odd count
    // carries only one byte.
    always_comb begin
        m_tvalid = (remain_reg != 6'd0);
        m_tlast  = (remain_reg == 6'd1);
        m_tuser  = !m_tlast || !count[0];
        m_tdata  = {(m_tuser ? drain_q[MAX_PARITY-2] : 8'd0), drain_q[MAX_PARITY-1]};
    end

endmodule
`default_nettype wire

/* verif/rsp_parity_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reed-Solomon parity checker
// Watches the configuration port and both stream channels of the parity unit.
// It keeps its own LFSR and predicts the parity words of every block. Each
// accepted parity word is then compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module rsp_parity_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          error_count,
    output int          words_outstanding
);

    localparam int LFSR_DEPTH = 68;

    // Parity byte count for each selection index.
    localparam int PARITY_BYTES [16] = '{
        5, 7, 10, 11, 12, 14, 18, 20, 24, 28, 36, 42, 48, 56, 62, 68
    };

    typedef struct {
        logic [7:0] first;
        logic [7:0] second;
        logic       second_valid;
        logic       final_pair;
    } parity_word_t;

    logic [7:0]   parity_lfsr [LFSR_DEPTH];
    logic [7:0]   gen_coeffs [LFSR_DEPTH + 1];
    int           parity_count;
    int           mismatches;
    parity_word_t parity_words_q [$];

    // Multiply in GF(256) over x^8 + x^5 + x^3 + x^2 + 1.
    function automatic logic [7:0] gf256_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] shifted;
        acc     = 8'd0;
        shifted = x;
        for (int b = 0; b < 8; b++) begin
            if (y[b]) begin
                acc = acc ^ shifted;
            end
            shifted = shifted[7] ? ({shifted[6:0], 1'b0} ^ 8'h2D) : {shifted[6:0], 1'b0};
        end
        return acc;
    endfunction

    // Build the generator polynomial as the product of (x + alpha^i) for
    // i = 1..n, and clear the LFSR, as a write of the selection does.
    function automatic void load_selection(input logic [3:0] sel);
        logic [7:0] root;
        parity_count = PARITY_BYTES[sel];
        foreach (gen_coeffs[j]) begin
            gen_coeffs[j] = 8'd0;
        end
        gen_coeffs[0] = 8'd1;
        root = 8'd1;
        for (int i = 1; i <= parity_count; i++) begin
            root = gf256_mul(root, 8'd2);
            for (int j = i; j > 0; j--) begin
                gen_coeffs[j] = gen_coeffs[j - 1] ^ gf256_mul(gen_coeffs[j], root);
            end
            gen_coeffs[0] = gf256_mul(gen_coeffs[0], root);
        end
        foreach (parity_lfsr[k]) begin
            parity_lfsr[k] = 8'd0;
        end
    endfunction

    // Shift one data word into the LFSR; on the last word of a block queue
    // the parity words, highest register first, and start over at zero.
    function automatic void absorb_word(input logic [7:0] data, input logic block_end);
        logic [7:0]   feedback;
        parity_word_t word;
        int           idx;
        feedback = parity_lfsr[parity_count - 1] ^ data;
        for (int k = parity_count - 1; k > 0; k--) begin
            parity_lfsr[k] = parity_lfsr[k - 1] ^ gf256_mul(feedback, gen_coeffs[k]);
        end
        parity_lfsr[0] = gf256_mul(feedback, gen_coeffs[0]);
        if (block_end) begin
            idx = parity_count - 1;
            while (idx >= 0) begin
                word.first        = parity_lfsr[idx];
                word.second       = (idx >= 1) ? parity_lfsr[idx - 1] : 8'd0;
                word.second_valid = (idx >= 1);
                idx               = idx - 2;
                word.final_pair   = (idx < 0);
                parity_words_q.push_back(word);
            end
            foreach (parity_lfsr[k]) begin
                parity_lfsr[k] = 8'd0;
            end
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Prediction and comparison, all on values sampled at the clock edge.
    always @(posedge aclk) begin : predict_and_compare
        parity_word_t want;
        if (!aresetn) begin
            load_selection(4'd0);
            parity_words_q.delete();
            mismatches = 0;
        end else begin
            if (cfg_wr_en) begin
                load_selection(cfg_wr_data);
            end
            if (s_tvalid && s_tready) begin
                absorb_word(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (parity_words_q.size() == 0) begin
                    $error("parity word 0x%h with no prediction waiting", m_tdata);
                    mismatches++;
                end else begin
                    want = parity_words_q.pop_front();
                    check_field("parity_first", want.first, m_tdata[7:0]);
                    check_field("parity_second", want.second, m_tdata[15:8]);
                    check_field("second_valid", want.second_valid, m_tuser);
                    check_field("final_pair", want.final_pair, m_tlast);
                end
            end
        end
        error_count       <= mismatches;
        words_outstanding <= parity_words_q.size();
    end

endmodule

/* verif/tb_reed_solomon_parity_gf256_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reed-Solomon parity unit testbench
// Drives data blocks under fixed and random generator selections, with
// bursty input and a stalling output side. The checker beside the unit
// predicts and compares the parity words; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_reed_solomon_parity_gf256_unit;

    localparam int TARGET_ITEMS  = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;

    localparam logic [3:0] SEL_FEWEST = 4'd0;
    localparam logic [3:0] SEL_SEVEN  = 4'd1;
    localparam logic [3:0] SEL_TWELVE = 4'd4;
    localparam logic [3:0] SEL_MOST   = 4'd15;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [3:0]  cfg_wr_data = 4'd0;
    logic        s_tvalid    = 1'b0;
    logic [7:0]  s_tdata     = 8'd0;
    logic        s_tlast     = 1'b0;
    logic        m_tready    = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int error_count;
    int words_outstanding;
    int cycle_count = 0;
    int items_sent  = 0;
    int burst_left  = 1;
    int stall_mode  = 0;
    int stall_left  = 0;

    reed_solomon_parity_gf256_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    rsp_parity_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .error_count       (error_count),
        .words_outstanding (words_outstanding)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver switches between always ready, random stalls and heavy
    // stalls, each held for a random stretch.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 64);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // Present one data word and wait for its handshake. After a burst the
    // sender drops s_tvalid and pauses before the next burst.
    task automatic send_word(input logic [7:0] data, input logic block_end);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= block_end;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_block(input int len);
        for (int i = 0; i < len; i++) begin
            send_word(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Stop sending and wait until every predicted parity word has come out.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
    endtask

    // The selection is only written once the unit is idle.
    task automatic write_selection(input logic [3:0] sel);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int  phase;
        int  blocks;
        int  pick;
        bit  abandoned;
        logic [3:0] sel;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset selection of five bytes (odd count): an all-zero block, a
        // one-word block of ones and a mixed block.
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b1);

        // A block left unfinished is abandoned by the next selection write.
        send_word(8'h5A, 1'b0);
        send_word(8'hC3, 1'b0);
        write_selection(SEL_MOST);
        send_word(8'hFF, 1'b0);
        send_word(8'h12, 1'b1);

        write_selection(SEL_SEVEN);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);

        write_selection(SEL_TWELVE);
        send_word(8'h7E, 1'b0);
        send_word(8'h81, 1'b1);

        // Last words back to back while the previous parity still drains.
        write_selection(SEL_FEWEST);
        send_word(8'h33, 1'b1);
        send_word(8'hCC, 1'b1);
        send_word(8'h0F, 1'b1);

        // Random phases: the first two use the extreme selections.
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (phase == 0) begin
                sel = SEL_FEWEST;
            end else if (phase == 1) begin
                sel = SEL_MOST;
            end else begin
                sel = 4'($urandom_range(0, 15));
            end
            write_selection(sel);
            blocks    = $urandom_range(1, 6);
            abandoned = 1'b0;
            for (int b = 0; b < blocks && !abandoned; b++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    send_block($urandom_range(1, 12));
                end else if (pick < 8) begin
                    send_block($urandom_range(13, 40));
                end else if (pick == 8) begin
                    send_block(1);
                end else begin
                    // Broken block: data words only, then a selection write.
                    repeat ($urandom_range(1, 8)) send_word(8'($urandom_range(0, 255)), 1'b0);
                    abandoned = 1'b1;
                end
            end
            phase++;
        end

        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/rsp_pkg.sv
hdl/rsp_lfsr_cell.sv
hdl/rsp_drain_cell.sv
hdl/reed_solomon_parity_gf256_unit.sv
verif/rsp_parity_checker.sv
verif/tb_reed_solomon_parity_gf256_unit.sv
